// ----- hdl/stf_pkg.sv -----
package stf_pkg;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = AW + 1;
  localparam int unsigned WW    = 32;

  localparam logic [WW-1:0] SENTINEL = {1'b1, {(WW-1){1'b0}}};

  typedef enum logic [2:0] {
    KIND_PUSH   = 3'd0,
    KIND_APPEND = 3'd1,
    KIND_DELETE = 3'd2,
    KIND_GET    = 3'd3,
    KIND_SET    = 3'd4,
    KIND_FIND   = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SENTINEL  = 3'd1,
    ST_BAD_SLOT  = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic          we;
    logic          re;
    logic [AW-1:0] addr;
    logic [WW-1:0] wdata;
  } slot_req_t;

  typedef struct packed {
    logic          we;
    logic          re;
    logic [AW-1:0] addr;
    logic [AW-1:0] wdata;
  } stack_req_t;

endpackage

// ----- hdl/stf_slot_ram.sv -----
module stf_slot_ram (
  input  logic                          clk_i,
  input  stf_pkg::slot_req_t            req_i,
  output logic [stf_pkg::WW-1:0]        rdata_o
);

  logic [stf_pkg::WW-1:0] mem [stf_pkg::DEPTH];
  logic [stf_pkg::WW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/stf_stack_ram.sv -----
module stf_stack_ram (
  input  logic                          clk_i,
  input  stf_pkg::stack_req_t           req_i,
  output logic [stf_pkg::AW-1:0]        rdata_o
);

  logic [stf_pkg::AW-1:0] mem [stf_pkg::DEPTH];
  logic [stf_pkg::AW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/stf_seq.sv -----
module stf_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    in_kind_i,
  input  logic [stf_pkg::AW-1:0]        in_slot_i,
  input  logic [stf_pkg::WW-1:0]        in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    out_status_o,
  output logic [stf_pkg::AW-1:0]        out_slot_o,
  output logic [stf_pkg::WW-1:0]        out_word_o,
  output logic [stf_pkg::CW-1:0]        out_fill_o,
  output logic [stf_pkg::CW-1:0]        out_live_o,
  output stf_pkg::slot_req_t            slot_req_o,
  input  logic [stf_pkg::WW-1:0]        slot_rdata_i,
  output stf_pkg::stack_req_t           stk_req_o,
  input  logic [stf_pkg::AW-1:0]        stk_rdata_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_POP   = 2'd2;
  localparam logic [1:0] S_FIND  = 2'd3;

  localparam logic [stf_pkg::CW-1:0] FULL_LVL = stf_pkg::CW'(stf_pkg::DEPTH);

  logic [1:0]               state_q, state_d;
  logic [2:0]               kind_q, kind_d;
  logic [stf_pkg::AW-1:0]   slot_q, slot_d;
  logic [stf_pkg::WW-1:0]   word_q, word_d;
  logic [stf_pkg::CW-1:0]   fill_q, fill_d;
  logic [stf_pkg::CW-1:0]   live_q, live_d;
  logic [stf_pkg::CW-1:0]   fdep_q, fdep_d;
  logic [stf_pkg::CW-1:0]   cnt_q, cnt_d;
  logic                     pend_q, pend_d;
  logic [stf_pkg::AW-1:0]   pidx_q, pidx_d;
  logic                     ovld_q, ovld_d;
  logic [2:0]               ost_q, ost_d;
  logic [stf_pkg::AW-1:0]   oslot_q, oslot_d;
  logic [stf_pkg::WW-1:0]   oword_q, oword_d;
  logic [stf_pkg::CW-1:0]   ofill_q, ofill_d;
  logic [stf_pkg::CW-1:0]   olive_q, olive_d;

  logic                     accept;
  logic                     fin;
  logic [stf_pkg::WW-1:0]   key;
  logic                     hit;

  assign in_ready_o = (state_q == S_IDLE) && (!ovld_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // shared comparator: vacancy test against the sentinel, or the search key
  assign key = (state_q == S_FIND) ? word_q : stf_pkg::SENTINEL;
  assign hit = (slot_rdata_i == key);

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    slot_d     = slot_q;
    word_d     = word_q;
    fill_d     = fill_q;
    live_d     = live_q;
    fdep_d     = fdep_q;
    cnt_d      = cnt_q;
    pend_d     = 1'b0;
    pidx_d     = pidx_q;
    ovld_d     = ovld_q && !out_ready_i;
    ost_d      = ost_q;
    oslot_d    = oslot_q;
    oword_d    = oword_q;
    fin        = 1'b0;
    slot_req_o = '0;
    stk_req_o  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d  = in_kind_i;
          slot_d  = in_slot_i;
          word_d  = in_word_i;
          ost_d   = stf_pkg::ST_OK;
          oslot_d = '0;
          oword_d = '0;
          case (in_kind_i) inside
            stf_pkg::KIND_PUSH, stf_pkg::KIND_APPEND: begin
              if (in_word_i == stf_pkg::SENTINEL) begin
                fin   = 1'b1;
                ost_d = stf_pkg::ST_SENTINEL;
              end else if (in_kind_i == stf_pkg::KIND_PUSH && fdep_q != '0) begin
                // reuse the most recently freed slot
                stk_req_o.re   = 1'b1;
                stk_req_o.addr = stf_pkg::AW'(fdep_q - 1'b1);
                state_d        = S_POP;
              end else if (fill_q >= FULL_LVL) begin
                fin   = 1'b1;
                ost_d = stf_pkg::ST_FULL;
              end else begin
                slot_req_o.we    = 1'b1;
                slot_req_o.addr  = fill_q[stf_pkg::AW-1:0];
                slot_req_o.wdata = in_word_i;
                oslot_d          = fill_q[stf_pkg::AW-1:0];
                fill_d           = fill_q + 1'b1;
                live_d           = live_q + 1'b1;
                fin              = 1'b1;
              end
            end
            stf_pkg::KIND_DELETE, stf_pkg::KIND_GET, stf_pkg::KIND_SET: begin
              if (in_kind_i == stf_pkg::KIND_SET && in_word_i == stf_pkg::SENTINEL) begin
                fin   = 1'b1;
                ost_d = stf_pkg::ST_SENTINEL;
              end else if (stf_pkg::CW'(in_slot_i) >= fill_q) begin
                fin   = 1'b1;
                ost_d = stf_pkg::ST_BAD_SLOT;
              end else begin
                slot_req_o.re   = 1'b1;
                slot_req_o.addr = in_slot_i;
                state_d         = S_CHECK;
              end
            end
            stf_pkg::KIND_FIND: begin
              cnt_d   = '0;
              state_d = S_FIND;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_CHECK: begin
        fin     = 1'b1;
        state_d = S_IDLE;
        case (kind_q)
          stf_pkg::KIND_GET: begin
            oword_d = slot_rdata_i;
          end
          stf_pkg::KIND_SET: begin
            if (hit) begin
              ost_d = stf_pkg::ST_BAD_SLOT;
            end else begin
              slot_req_o.we    = 1'b1;
              slot_req_o.addr  = slot_q;
              slot_req_o.wdata = word_q;
            end
          end
          default: begin
            if (hit || fdep_q >= FULL_LVL) begin
              ost_d = stf_pkg::ST_BAD_SLOT;
            end else begin
              stk_req_o.we     = 1'b1;
              stk_req_o.addr   = fdep_q[stf_pkg::AW-1:0];
              stk_req_o.wdata  = slot_q;
              fdep_d           = fdep_q + 1'b1;
              slot_req_o.we    = 1'b1;
              slot_req_o.addr  = slot_q;
              slot_req_o.wdata = stf_pkg::SENTINEL;
              if (live_q != '0) begin
                live_d = live_q - 1'b1;
              end
            end
          end
        endcase
      end

      S_POP: begin
        slot_req_o.we    = 1'b1;
        slot_req_o.addr  = stk_rdata_i;
        slot_req_o.wdata = word_q;
        oslot_d          = stk_rdata_i;
        fdep_d           = fdep_q - 1'b1;
        live_d           = live_q + 1'b1;
        fin              = 1'b1;
        state_d          = S_IDLE;
      end

      S_FIND: begin
        // one read issued per cycle; each read is compared in the cycle after it
        if (pend_q && hit) begin
          oslot_d = pidx_q;
          fin     = 1'b1;
          state_d = S_IDLE;
        end else if (cnt_q < fill_q) begin
          slot_req_o.re   = 1'b1;
          slot_req_o.addr = cnt_q[stf_pkg::AW-1:0];
          pend_d          = 1'b1;
          pidx_d          = cnt_q[stf_pkg::AW-1:0];
          cnt_d           = cnt_q + 1'b1;
        end else begin
          ost_d   = stf_pkg::ST_NOT_FOUND;
          fin     = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      ovld_d = 1'b1;
    end
    ofill_d = fin ? fill_d : ofill_q;
    olive_d = fin ? live_d : olive_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      live_q  <= '0;
      fdep_q  <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      live_q  <= live_d;
      fdep_q  <= fdep_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    slot_q  <= slot_d;
    word_q  <= word_d;
    pidx_q  <= pidx_d;
    ost_q   <= ost_d;
    oslot_q <= oslot_d;
    oword_q <= oword_d;
    ofill_q <= ofill_d;
    olive_q <= olive_d;
  end

  assign out_valid_o  = ovld_q;
  assign out_status_o = ost_q;
  assign out_slot_o   = oslot_q;
  assign out_word_o   = oword_q;
  assign out_fill_o   = ofill_q;
  assign out_live_o   = olive_q;

  a_out_free_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !ovld_q)
    else $error("result word pending while an operation is in flight");

  a_slot_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, live_q} + {1'b0, fdep_q}) == {1'b0, fill_q})
    else $error("live count plus freed slots differs from fill level");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL_LVL)
    else $error("fill level beyond capacity");

  a_find_keeps_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIND) |=> (fill_q == $past(fill_q)))
    else $error("fill level moved during search");

  a_find_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIND && pend_q) |-> (stf_pkg::CW'(pidx_q) < fill_q))
    else $error("search read beyond fill level");

endmodule

// ----- hdl/slot_table_with_free_stack_core.sv -----
// Slot table with a LIFO stack of freed slots, 1024 words of 32 bits.
// Input stream: s_axis_tuser carries the operation (push, append, delete,
// get, set, find); s_axis_tdata carries the slot index and the word.
// Output stream: one result word per input word, holding status, slot,
// read word, fill level and live count after the operation.
// One operation is in flight at a time; s_axis_tready is low while it runs.
// Steps from accept to result valid, set by the single-port slot RAM with
// its registered read and by the shared comparator:
//   append, sentinel or range errors, unused kinds: registered at accept
//   delete, set: read, check, write; get: read, check; push: pop, write
//   find: one slot compared per cycle until a hit or the fill level
// The result sits in an output register; the next word is taken in the
// same cycle that the pending result is taken. While m_axis_tready is low
// the result holds and no new word is accepted.
// Reset clears fill level, live count and stack depth at once; the RAM
// contents are not cleared, since only written entries are ever read.
module slot_table_with_free_stack_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // slot[9:0], word[41:10], zero[47:42]
  input  logic [2:0]  s_axis_tuser,  // kind[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], slot_out[12:3], word_out[44:13], fill_level[55:45],
  // live_count[66:56], zero[71:67]
  output logic [71:0] m_axis_tdata
);

  stf_pkg::slot_req_t        slot_req;
  stf_pkg::stack_req_t       stk_req;
  logic [stf_pkg::WW-1:0]    slot_rdata;
  logic [stf_pkg::AW-1:0]    stk_rdata;
  logic [2:0]                out_status;
  logic [stf_pkg::AW-1:0]    out_slot;
  logic [stf_pkg::WW-1:0]    out_word;
  logic [stf_pkg::CW-1:0]    out_fill;
  logic [stf_pkg::CW-1:0]    out_live;

  stf_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_kind_i    (s_axis_tuser),
    .in_slot_i    (s_axis_tdata[9:0]),
    .in_word_i    (s_axis_tdata[41:10]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_slot_o   (out_slot),
    .out_word_o   (out_word),
    .out_fill_o   (out_fill),
    .out_live_o   (out_live),
    .slot_req_o   (slot_req),
    .slot_rdata_i (slot_rdata),
    .stk_req_o    (stk_req),
    .stk_rdata_i  (stk_rdata)
  );

  stf_slot_ram u_slot_ram (
    .clk_i   (clk_i),
    .req_i   (slot_req),
    .rdata_o (slot_rdata)
  );

  stf_stack_ram u_stack_ram (
    .clk_i   (clk_i),
    .req_i   (stk_req),
    .rdata_o (stk_rdata)
  );

  assign m_axis_tdata = {5'b0, out_live, out_fill, out_word, out_slot, out_status};

endmodule
